// File: rtl/core/tcp_packet_route_classifier_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the route classifier
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TCP_PACKET_ROUTE_CLASSIFIER_UNIT_MACROS_SVH
`define TCP_PACKET_ROUTE_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TRPC_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("route classifier check failed");

// Next-cycle implication, ignored while reset is asserted.
`define TRPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("route classifier check failed");

`endif

// File: rtl/core/trpc_pkg.sv
// ----------------------------------------------------------------------------
// trpc_pkg
// Types, constants and helper functions of the TCP route classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package trpc_pkg;

  localparam int KEY_W = 48;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [5:0]  PLEN_MAX       = 6'd48;
  localparam logic [7:0]  ACT_DROP       = 8'd1;
  localparam logic [7:0]  ACT_TX         = 8'd2;

  typedef enum logic [1:0] {
    VERDICT_PASS = 2'd0,
    VERDICT_DROP = 2'd1,
    VERDICT_TX   = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_OUT
  } state_t;

  // Route table write, broadcast to every cell.
  typedef struct packed {
    logic        en;
    logic [7:0]  index;
    logic        valid;
    logic [5:0]  plen;
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  action;
  } route_wr_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic       valid;
    logic       found;
    logic [5:0] best_len;
    logic [7:0] action;
  } token_t;

  // Frame summary from the parser.
  typedef struct packed {
    logic             done;
    logic             ok;
    logic [KEY_W-1:0] key;
  } frame_t;

  // Mask of the leading plen key bits; plen is at most KEY_W.
  function automatic logic [KEY_W-1:0] prefix_mask(input logic [5:0] plen);
    logic [6:0] sh;
    sh = 7'(KEY_W) - {1'b0, plen};
    return {KEY_W{1'b1}} << sh;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/trpc_if.sv
// ----------------------------------------------------------------------------
// trpc_in_if / trpc_out_if
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface trpc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [7:0]  entry_index;
  logic        entry_valid;
  logic [5:0]  entry_prefix_len;
  logic [31:0] entry_dest_ip;
  logic [15:0] entry_dest_port;
  logic [7:0]  entry_action;

  modport source (output valid, cmd, data_byte, last_byte, entry_index, entry_valid,
                  entry_prefix_len, entry_dest_ip, entry_dest_port, entry_action,
                  input ready);
  modport sink (input valid, cmd, data_byte, last_byte, entry_index, entry_valid,
                entry_prefix_len, entry_dest_ip, entry_dest_port, entry_action,
                output ready);
endinterface

interface trpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic        route_matched;
  logic        was_tcp_ipv4;
  logic [31:0] total_count;
  logic [31:0] passed_count;
  logic [31:0] dropped_count;

  modport source (output valid, verdict, route_matched, was_tcp_ipv4, total_count,
                  passed_count, dropped_count, input ready);
  modport sink (input valid, verdict, route_matched, was_tcp_ipv4, total_count,
                passed_count, dropped_count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/trpc_parser.sv
// ----------------------------------------------------------------------------
// trpc_parser
// Captures the header fields of a frame byte by byte and checks them at the
// last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module trpc_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            take,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  output trpc_pkg::frame_t     frame
);
  import trpc_pkg::*;

  logic [6:0]  off_r,   off_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [7:0]  vihl_r,  vihl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] daddr_r, daddr_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [6:0]  port_at;
  logic [6:0]  len;
  logic [7:0]  tcp_end;
  logic        ok;
  frame_t      frame_r;

  // Field capture: the current offset selects which header byte this is.
  always_comb begin
    etype_nxt = etype_r;
    vihl_nxt  = vihl_r;
    proto_nxt = proto_r;
    daddr_nxt = daddr_r;
    dport_nxt = dport_r;
    port_at   = 7'({vihl_r[3:0], 2'b00}) + 7'd16;
    if (off_r == 7'd12) etype_nxt[15:8] = data_byte;
    if (off_r == 7'd13) etype_nxt[7:0]  = data_byte;
    if (off_r == 7'd14) vihl_nxt        = data_byte;
    if (off_r == 7'd23) proto_nxt       = data_byte;
    if (off_r == 7'd30) daddr_nxt[31:24] = data_byte;
    if (off_r == 7'd31) daddr_nxt[23:16] = data_byte;
    if (off_r == 7'd32) daddr_nxt[15:8]  = data_byte;
    if (off_r == 7'd33) daddr_nxt[7:0]   = data_byte;
    if (off_r > 7'd14 && off_r == port_at)         dport_nxt[15:8] = data_byte;
    if (off_r > 7'd14 && off_r == port_at + 7'd1)  dport_nxt[7:0]  = data_byte;
  end

  // Length after this byte, saturating at the top of the offset counter.
  always_comb begin
    len     = (off_r == 7'd127) ? off_r : off_r + 7'd1;
    off_nxt = last_byte ? 7'd0 : len;
    tcp_end = 8'({vihl_nxt[3:0], 2'b00}) + 8'd34;
    ok = (len >= 7'd14) && (etype_nxt == ETHERTYPE_IPV4) && (len >= 7'd34)
      && (vihl_nxt[7:4] == IP_VERSION_4) && (proto_nxt == PROTO_TCP)
      && ({1'b0, len} >= tcp_end);
  end

  // Header registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      etype_r <= '0;
      vihl_r  <= '0;
      proto_r <= '0;
      daddr_r <= '0;
      dport_r <= '0;
    end else if (take) begin
      off_r   <= off_nxt;
      etype_r <= etype_nxt;
      vihl_r  <= vihl_nxt;
      proto_r <= proto_nxt;
      daddr_r <= daddr_nxt;
      dport_r <= dport_nxt;
    end
  end

  // Frame summary, raised for one cycle after the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r.done <= 1'b0;
    end else begin
      frame_r.done <= take && last_byte;
    end
    if (take && last_byte) begin
      frame_r.ok  <= ok;
      frame_r.key <= {daddr_nxt, dport_nxt};
    end
  end

  assign frame = frame_r;

endmodule

`default_nettype wire

// File: rtl/core/trpc_cell.sv
// ----------------------------------------------------------------------------
// trpc_cell
// One route table slot. Compares the frame key with its entry and passes the
// best match so far on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module trpc_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  trpc_pkg::route_wr_t                wr,
  input  wire logic [trpc_pkg::KEY_W-1:0]    key,
  input  trpc_pkg::token_t                   tok_in,
  output trpc_pkg::token_t                   tok_out
);
  import trpc_pkg::*;

  logic        valid_r;
  logic [5:0]  plen_r;
  logic [31:0] ip_r;
  logic [15:0] port_r;
  logic [7:0]  action_r;
  logic        hit;
  logic        match;
  logic        better;
  token_t      tok_r;

  assign hit = wr.en && (32'(wr.index) == CELL_IDX);

  // Entry storage; the prefix length is clamped to the key width on write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (hit) begin
      valid_r <= wr.valid;
    end
    if (hit) begin
      plen_r   <= (wr.plen > PLEN_MAX) ? PLEN_MAX : wr.plen;
      ip_r     <= wr.ip;
      port_r   <= wr.port;
      action_r <= wr.action;
    end
  end

  // A strictly longer prefix replaces the earlier best, so lower slots win ties.
  assign match  = valid_r && ((({ip_r, port_r} ^ key) & prefix_mask(plen_r)) == '0);
  assign better = match && (!tok_in.found || plen_r > tok_in.best_len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_in.valid;
    end
    tok_r.found    <= tok_in.found || match;
    tok_r.best_len <= better ? plen_r : tok_in.best_len;
    tok_r.action   <= better ? action_r : tok_in.action;
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// File: rtl/core/tcp_packet_route_classifier_unit.sv
// ----------------------------------------------------------------------------
// tcp_packet_route_classifier_unit
// Classifies TCP over IPv4 frames by longest-prefix match of the destination
// address and port against a route table, and keeps frame counters.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per cycle. After the last byte of a frame the
// input is held off until its result has been taken: the frame first passes
// the header check state, then, for a frame that passes it, the search state
// while the search token walks the row of route cells, one cell per cycle.
// Route writes produce no result. Writes to a slot at or beyond
// ROUTE_ENTRIES are ignored.
`default_nettype none

module tcp_packet_route_classifier_unit #(
  parameter int ROUTE_ENTRIES = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  trpc_in_if.sink    in_chan,
  trpc_out_if.source out_chan
);
  import trpc_pkg::*;

  `include "tcp_packet_route_classifier_unit_macros.svh"

  state_t      state_r, state_nxt;
  logic        in_take;
  logic        out_take;
  frame_t      frame;
  route_wr_t   wr;
  token_t      tok [0:ROUTE_ENTRIES];
  logic [KEY_W-1:0] key_r;
  logic        finish;
  logic        fin_ok;
  logic        fin_found;
  logic [7:0]  fin_action;
  verdict_t    verdict_r;
  logic        matched_r;
  logic        tcp_r;
  logic [31:0] total_r, passed_r, dropped_r;
  verdict_t    fin_verdict;

  assign in_take  = in_chan.valid && in_chan.ready;
  assign out_take = out_chan.valid && out_chan.ready;

  // Header parser.
  trpc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take && !in_chan.cmd),
    .data_byte (in_chan.data_byte),
    .last_byte (in_chan.last_byte),
    .frame     (frame)
  );

  // Route write broadcast.
  always_comb begin
    wr.en     = in_take && in_chan.cmd;
    wr.index  = in_chan.entry_index;
    wr.valid  = in_chan.entry_valid;
    wr.plen   = in_chan.entry_prefix_len;
    wr.ip     = in_chan.entry_dest_ip;
    wr.port   = in_chan.entry_dest_port;
    wr.action = in_chan.entry_action;
  end

  // The key is held steady during the search.
  always_ff @(posedge clk) begin
    if (frame.done) begin
      key_r <= frame.key;
    end
  end

  // Search token launched into the first cell.
  always_comb begin
    tok[0].valid    = (state_r == S_CHECK) && frame.ok;
    tok[0].found    = 1'b0;
    tok[0].best_len = '0;
    tok[0].action   = '0;
  end

  // Row of route cells.
  for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
    trpc_cell #(.CELL_IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .key     ((state_r == S_CHECK) ? frame.key : key_r),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // State machine.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    finish     = 1'b0;
    fin_ok     = 1'b0;
    fin_found  = 1'b0;
    fin_action = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_take && !in_chan.cmd && in_chan.last_byte) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (frame.ok) begin
          state_nxt = S_SEARCH;
        end else begin
          finish    = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_SEARCH: begin
        if (tok[ROUTE_ENTRIES].valid) begin
          finish     = 1'b1;
          fin_ok     = 1'b1;
          fin_found  = tok[ROUTE_ENTRIES].found;
          fin_action = tok[ROUTE_ENTRIES].action;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Verdict from the winning entry's action.
  always_comb begin
    fin_verdict = VERDICT_PASS;
    if (fin_found && fin_action == ACT_DROP) fin_verdict = VERDICT_DROP;
    if (fin_found && fin_action == ACT_TX)   fin_verdict = VERDICT_TX;
  end

  // Counters and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      passed_r  <= '0;
      dropped_r <= '0;
    end else if (finish) begin
      total_r <= total_r + 32'd1;
      if (fin_ok && fin_verdict == VERDICT_DROP) dropped_r <= dropped_r + 32'd1;
      if (fin_ok && fin_verdict != VERDICT_DROP) passed_r  <= passed_r + 32'd1;
    end
    if (finish) begin
      verdict_r <= fin_verdict;
      matched_r <= fin_found;
      tcp_r     <= fin_ok;
    end
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = (state_r == S_OUT);
  assign out_chan.verdict       = verdict_r;
  assign out_chan.route_matched = matched_r;
  assign out_chan.was_tcp_ipv4  = tcp_r;
  assign out_chan.total_count   = total_r;
  assign out_chan.passed_count  = passed_r;
  assign out_chan.dropped_count = dropped_r;

  // Checks on the sequencing of a frame.
  `TRPC_ASSERT_SAME(a_tok_in_search, clk, rst_n, tok[ROUTE_ENTRIES].valid, state_r == S_SEARCH)
  `TRPC_ASSERT_NEXT(a_out_to_idle, clk, rst_n, out_take, state_r == S_IDLE)
  `TRPC_ASSERT_NEXT(a_fail_skips, clk, rst_n, state_r == S_CHECK && !frame.ok, out_chan.valid)

endmodule

`default_nettype wire

// File: tb/tcp_packet_route_classifier_unit_tb.sv
// ----------------------------------------------------------------------------
// tcp_packet_route_classifier_unit_tb
// Streams route writes and Ethernet frames into the classifier, predicts each
// verdict and the frame counters, and compares every result item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_packet_route_classifier_unit_tb;
  import trpc_pkg::*;

  localparam int NUM_SLOTS = 256;
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_ROUTE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  entry_index;
    logic        entry_valid;
    logic [5:0]  entry_prefix_len;
    logic [31:0] entry_dest_ip;
    logic [15:0] entry_dest_port;
    logic [7:0]  entry_action;
  } item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        route_matched;
    logic        was_tcp_ipv4;
    logic [31:0] total_count;
    logic [31:0] passed_count;
    logic [31:0] dropped_count;
  } verdict_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  trpc_in_if  in_chan ();
  trpc_out_if out_chan ();

  tcp_packet_route_classifier_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always #1 clk = ~clk;

  // Predictor state.
  logic [6:0]  frame_pos;
  logic [15:0] seen_ethertype;
  logic [7:0]  seen_ver_ihl;
  logic [7:0]  seen_proto;
  logic [31:0] seen_dst_ip;
  logic [15:0] seen_dst_port;
  logic        route_on [NUM_SLOTS];
  logic [5:0]  route_plen [NUM_SLOTS];
  logic [47:0] route_cmp_key [NUM_SLOTS];
  logic [7:0]  route_act [NUM_SLOTS];
  logic [31:0] cnt_total, cnt_passed, cnt_dropped;

  item_t        pending_items[$];
  verdict_rec_t expected_verdicts[$];
  int           error_count = 0;
  bit           feeding_done = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  // Works out the result, if any, of one accepted item.
  task automatic predict_classification(input item_t it);
    int unsigned port_at, flen, best_len, plen;
    logic ok, found;
    logic [47:0] key, mask;
    logic [7:0] act;
    verdict_rec_t r;
    if (it.cmd == CMD_ROUTE) begin
      route_on[it.entry_index]      = it.entry_valid;
      route_plen[it.entry_index]    = it.entry_prefix_len;
      route_cmp_key[it.entry_index] = {it.entry_dest_ip, it.entry_dest_port};
      route_act[it.entry_index]     = it.entry_action;
      return;
    end
    port_at = 14 + 4 * seen_ver_ihl[3:0] + 2;
    case (frame_pos)
      12: seen_ethertype[15:8] = it.data_byte;
      13: seen_ethertype[7:0]  = it.data_byte;
      14: seen_ver_ihl = it.data_byte;
      23: seen_proto = it.data_byte;
      30: seen_dst_ip[31:24] = it.data_byte;
      31: seen_dst_ip[23:16] = it.data_byte;
      32: seen_dst_ip[15:8]  = it.data_byte;
      33: seen_dst_ip[7:0]   = it.data_byte;
      default: ;
    endcase
    if (frame_pos > 14 && frame_pos == port_at) seen_dst_port[15:8] = it.data_byte;
    if (frame_pos > 14 && frame_pos == port_at + 1) seen_dst_port[7:0] = it.data_byte;
    if (frame_pos < 127) frame_pos++;
    if (!it.last_byte) return;
    flen = frame_pos;
    frame_pos = '0;
    cnt_total++;
    ok = flen >= 14 && seen_ethertype == ETHERTYPE_IPV4 && flen >= 34 &&
         seen_ver_ihl[7:4] == IP_VERSION_4 && seen_proto == PROTO_TCP &&
         flen >= 14 + 4 * seen_ver_ihl[3:0] + 20;
    r = '0;
    r.verdict = VERDICT_PASS;
    if (ok) begin
      key = {seen_dst_ip, seen_dst_port};
      found = 0;
      best_len = 0;
      act = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!route_on[i]) continue;
        plen = (route_plen[i] > 48) ? 48 : route_plen[i];
        mask = (plen == 0) ? 48'd0 : ~48'd0 << (48 - plen);
        if (((route_cmp_key[i] ^ key) & mask) != 0) continue;
        if (!found || plen > best_len) begin
          found = 1;
          best_len = plen;
          act = route_act[i];
        end
      end
      if (found) begin
        r.route_matched = 1'b1;
        if (act == ACT_DROP) r.verdict = VERDICT_DROP;
        else if (act == ACT_TX) r.verdict = VERDICT_TX;
      end
      if (r.verdict == VERDICT_DROP) cnt_dropped++;
      else cnt_passed++;
    end
    r.was_tcp_ipv4 = ok;
    r.total_count = cnt_total;
    r.passed_count = cnt_passed;
    r.dropped_count = cnt_dropped;
    expected_verdicts.push_back(r);
  endtask

  function automatic item_t route_item(input logic [7:0] idx, input logic on,
                                       input logic [5:0] plen, input logic [47:0] key,
                                       input logic [7:0] act);
    item_t it;
    it = '0;
    it.cmd = CMD_ROUTE;
    it.data_byte = 8'($urandom);
    it.last_byte = 1'($urandom);
    it.entry_index = idx;
    it.entry_valid = on;
    it.entry_prefix_len = plen;
    it.entry_dest_ip = key[47:16];
    it.entry_dest_port = key[15:0];
    it.entry_action = act;
    return it;
  endfunction

  // Queues a frame of flen bytes; the IPv4 and TCP header fields are filled in when tcp is set.
  task automatic queue_frame(input int flen, input bit tcp, input logic [3:0] ihl,
                             input logic [47:0] key);
    item_t it;
    logic [7:0] b;
    int port_at;
    port_at = 14 + 4 * ihl + 2;
    for (int i = 0; i < flen; i++) begin
      b = 8'($urandom);
      if (tcp) begin
        if (i == 12) b = 8'h08;
        if (i == 13) b = 8'h00;
        if (i == 14) b = {IP_VERSION_4, ihl};
        if (i == 23) b = PROTO_TCP;
        if (i >= 30 && i <= 33) b = key[47 - 8 * (i - 30) -: 8];
        if (i == port_at) b = key[15:8];
        if (i == port_at + 1) b = key[7:0];
      end
      it = '0;
      it.cmd = CMD_BYTE;
      it.data_byte = b;
      it.last_byte = (i == flen - 1);
      it.entry_index = 8'($urandom);
      it.entry_valid = 1'($urandom);
      it.entry_prefix_len = 6'($urandom);
      it.entry_dest_ip = $urandom;
      it.entry_dest_port = 16'($urandom);
      it.entry_action = 8'($urandom);
      pending_items.push_back(it);
    end
  endtask

  // Stimulus: directed frames and routes, then random mixes.
  initial begin
    logic [47:0] keys [8];
    logic [47:0] k;
    logic [3:0] ihl;
    int flen;
    for (int i = 0; i < 8; i++) keys[i] = {$urandom, 16'($urandom)};
    // Directed: extremes of prefix length, equal lengths, all actions.
    pending_items.push_back(route_item(8'd0, 1'b1, 6'd0, 48'd0, ACT_TX));
    pending_items.push_back(route_item(8'd255, 1'b1, 6'd48, keys[0], ACT_DROP));
    pending_items.push_back(route_item(8'd10, 1'b1, 6'd63, keys[1], 8'hFF));
    pending_items.push_back(route_item(8'd20, 1'b1, 6'd16, keys[2], ACT_DROP));
    pending_items.push_back(route_item(8'd21, 1'b1, 6'd16, keys[2], ACT_TX));
    queue_frame(54, 1, 4'd5, keys[0]);
    queue_frame(54, 1, 4'd5, keys[1]);
    queue_frame(54, 1, 4'd5, keys[2]);
    queue_frame(54, 1, 4'd15, keys[3]);
    queue_frame(100, 1, 4'd15, keys[3]);
    queue_frame(40, 1, 4'd0, keys[0]);
    queue_frame(130, 1, 4'd5, keys[0]);
    queue_frame(1, 0, 4'd0, 48'd0);
    queue_frame(13, 1, 4'd5, keys[0]);
    queue_frame(33, 1, 4'd5, keys[0]);
    pending_items.push_back(route_item(8'd0, 1'b0, 6'd0, 48'd0, 8'd0));
    queue_frame(54, 0, 4'd5, keys[0]);
    // Random: mostly well-formed TCP frames with route writes mixed in.
    while (pending_items.size() < 1350) begin
      if ($urandom_range(0, 3) == 0) begin
        k = keys[$urandom_range(0, 7)];
        pending_items.push_back(route_item(8'($urandom_range(0, 15) == 0 ?
          $urandom : $urandom_range(0, 31)), 1'($urandom_range(0, 4) != 0),
          6'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 48)),
          $urandom_range(0, 1) ? k : {$urandom, 16'($urandom)},
          8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3))));
      end else begin
        ihl = $urandom_range(0, 5) == 0 ? 4'($urandom) : 4'd5;
        flen = $urandom_range(0, 7) == 0 ? $urandom_range(1, 140) :
               14 + 4 * ihl + 20 + $urandom_range(0, 6);
        k = keys[$urandom_range(0, 7)];
        if ($urandom_range(0, 2) == 0) k[$urandom_range(0, 47)] ^= 1'b1;
        queue_frame(flen, $urandom_range(0, 9) != 0, ihl, k);
      end
    end
  end

  // Driver: bursts of items with random gaps.
  int burst_left = 0, gap_left = 0;
  item_t cur_item;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      {in_chan.cmd, in_chan.data_byte, in_chan.last_byte, in_chan.entry_index,
       in_chan.entry_valid, in_chan.entry_prefix_len, in_chan.entry_dest_ip,
       in_chan.entry_dest_port, in_chan.entry_action} <= '0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (in_chan.valid) predict_classification(cur_item);
      if (gap_left > 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        in_chan.valid <= 1'b1;
        {in_chan.cmd, in_chan.data_byte, in_chan.last_byte, in_chan.entry_index,
         in_chan.entry_valid, in_chan.entry_prefix_len, in_chan.entry_dest_ip,
         in_chan.entry_dest_port, in_chan.entry_action} <= cur_item;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 40);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_chan.valid <= 1'b0;
        feeding_done = 1;
      end
    end
  end

  // Receiver stall pattern and result checks.
  int stall_phase = 0;
  always @(posedge clk) begin
    verdict_rec_t exp_r;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result item with none expected");
        end else begin
          exp_r = expected_verdicts.pop_front();
          if (out_chan.verdict !== exp_r.verdict) report_mismatch("verdict");
          if (out_chan.route_matched !== exp_r.route_matched) report_mismatch("route_matched");
          if (out_chan.was_tcp_ipv4 !== exp_r.was_tcp_ipv4) report_mismatch("was_tcp_ipv4");
          if (out_chan.total_count !== exp_r.total_count) report_mismatch("total_count");
          if (out_chan.passed_count !== exp_r.passed_count) report_mismatch("passed_count");
          if (out_chan.dropped_count !== exp_r.dropped_count) report_mismatch("dropped_count");
        end
      end
      stall_phase = (stall_phase + 1) % 97;
      out_chan.ready <= stall_phase < 40 ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // Reset, then wait for the stream to drain.
  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      route_on[i] = 0; route_plen[i] = '0; route_cmp_key[i] = '0; route_act[i] = '0;
    end
    frame_pos = '0; seen_ethertype = '0; seen_ver_ihl = '0; seen_proto = '0;
    seen_dst_ip = '0; seen_dst_port = '0;
    cnt_total = '0; cnt_passed = '0; cnt_dropped = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (feeding_done && expected_verdicts.size() == 0);
    repeat (600) @(posedge clk);
    if (error_count == 0 && expected_verdicts.size() == 0)
      $display("tcp_packet_route_classifier_unit_tb: clean");
    else
      $display("tcp_packet_route_classifier_unit_tb: errors");
    $finish;
  end

  // Run time limit.
  initial begin
    #4000000;
    $display("tcp_packet_route_classifier_unit_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/trpc_pkg.sv
rtl/core/trpc_if.sv
rtl/core/trpc_parser.sv
rtl/core/trpc_cell.sv
rtl/core/tcp_packet_route_classifier_unit.sv
tb/tcp_packet_route_classifier_unit_tb.sv
